// ----- rtl/gasp_pkg.sv -----
// Shared types, codes and constants of the grid path search block.
`default_nettype none
package gasp_pkg;

    // Default grid geometry and tile cost width.
    localparam int GRID_WIDTH_DEF  = 8;
    localparam int GRID_HEIGHT_DEF = 8;
    localparam int COST_BITS_DEF   = 4;

    // Fixed field widths.
    localparam int XY_W       = 3;
    localparam int SIZE_W     = 4;
    localparam int TCOST_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Path cost width and its saturation value.
    localparam int COST_W = 10;
    localparam logic [COST_W-1:0] COST_SAT = 10'd1023;

    // Estimated total cost: path cost plus two coordinate distances.
    localparam int F_W = COST_W + 1;

    // Request kinds.
    localparam logic REQ_TILE   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_U  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_U = 2'd3;

    // Neighbor and parent directions.
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [XY_W-1:0]   cell_x;
        logic [XY_W-1:0]   cell_y;
        logic [TCOST_W-1:0] tile_cost;
        logic              tile_walkable;
    } req_t;

    typedef struct packed {
        logic [XY_W-1:0] step_x;
        logic [XY_W-1:0] step_y;
        logic            path_found;
        logic            last_step;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tile_wr;
        logic srch_load;
        logic start_open;
        logic scan_clr;
        logic scan_step;
        logic expand;
        logic nb_rd;
        logic nb_upd;
        logic bt_init;
        logic bt_rd;
        logic bt_emit;
        logic emit_none;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_bounds;
        logic scan_done;
        logic any_open;
        logic best_goal;
        logic dir_last;
        logic bt_last;
    } sts_t;

endpackage
`default_nettype wire

// ----- rtl/gasp_ctrl.sv -----
// Sequencing state machine of the grid path search.
`default_nettype none
module gasp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          req_type,
    input  wire gasp_pkg::sts_t sts,
    output gasp_pkg::cmd_t     cmd,
    output logic               busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_DECIDE,
        ST_NB_RD,
        ST_NB_UPD,
        ST_BT_RD,
        ST_BT_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Next state and commands for the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // A request is taken only once the final result has been shown.
                if (start && !busy_reg)
                begin
                    if (req_type == gasp_pkg::REQ_SEARCH)
                    begin
                        cmd.srch_load = 1'b1;
                        state_next    = ST_INIT;
                    end
                    else
                    begin
                        cmd.tile_wr = 1'b1;
                    end
                end
            end
            ST_INIT:
            begin
                if (sts.bad_bounds)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.start_open = 1'b1;
                    cmd.scan_clr   = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (!sts.any_open)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (sts.best_goal)
                begin
                    cmd.bt_init = 1'b1;
                    state_next  = ST_BT_RD;
                end
                else
                begin
                    cmd.expand = 1'b1;
                    state_next = ST_NB_RD;
                end
            end
            ST_NB_RD:
            begin
                cmd.nb_rd  = 1'b1;
                state_next = ST_NB_UPD;
            end
            ST_NB_UPD:
            begin
                cmd.nb_upd = 1'b1;
                if (sts.dir_last)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end
                else
                begin
                    state_next = ST_NB_RD;
                end
            end
            ST_BT_RD:
            begin
                cmd.bt_rd  = 1'b1;
                state_next = ST_BT_EMIT;
            end
            ST_BT_EMIT:
            begin
                cmd.bt_emit = 1'b1;
                state_next  = sts.bt_last ? ST_IDLE : ST_BT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Stay busy through the cycle that shows a final result.
        busy_next = (state_next != ST_IDLE) || cmd.emit_none || cmd.bt_emit;
    end

    // State and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

// ----- rtl/gasp_dp.sv -----
// Datapath of the grid path search: maps, search flags, open set scan and backtrack.
`default_nettype none
module gasp_dp #(
    parameter int GRID_WIDTH  = gasp_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gasp_pkg::GRID_HEIGHT_DEF,
    parameter int COST_BITS   = gasp_pkg::COST_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire gasp_pkg::req_t                     req,
    input  wire logic                               cfg_we,
    input  wire logic [gasp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gasp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire gasp_pkg::cmd_t                     cmd,
    output gasp_pkg::sts_t                          sts,
    output gasp_pkg::rsp_t                          result,
    output logic                                    result_strobe
);

    localparam int CELLS     = GRID_WIDTH * GRID_HEIGHT;
    localparam int CELL_BITS = $clog2(CELLS);
    localparam int CNT_W     = CELL_BITS + 1;
    localparam int XW        = gasp_pkg::XY_W;
    localparam int SW        = gasp_pkg::SIZE_W;
    localparam int CW        = gasp_pkg::COST_W;
    localparam int FW        = gasp_pkg::F_W;
    localparam int REC_W     = 2 + CW + CELL_BITS;
    localparam int TILE_W    = COST_BITS + 1;
    localparam logic [CELL_BITS-1:0] LAST_CELL = CELL_BITS'(CELLS - 1);
    localparam logic [CNT_W-1:0]     LAST_CNT  = CNT_W'(CELLS - 1);
    localparam logic [SW-1:0]        GW_S      = SW'(GRID_WIDTH);
    localparam logic [SW-1:0]        GH_S      = SW'(GRID_HEIGHT);

    function automatic logic [CELL_BITS-1:0] idx_of(input logic [XW-1:0] x,
                                                    input logic [XW-1:0] y);
        idx_of = CELL_BITS'(int'(y) * GRID_WIDTH + int'(x));
    endfunction

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                 input logic [SW-1:0] top);
        logic [SW-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SW'(1);
        end
        else if (v > top)
        begin
            r = top;
        end
        clamp_size = r;
    endfunction

    function automatic logic [XW-1:0] abs_diff(input logic [XW-1:0] a,
                                               input logic [XW-1:0] b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

    // Configuration registers.
    logic [XW-1:0] dx_reg, dy_reg;
    logic [SW-1:0] wu_reg, hu_reg;

    // Search context latched at search start.
    logic [XW-1:0] sx_reg, sy_reg, tx_reg, ty_reg;
    logic [SW-1:0] w_reg, h_reg;

    // Tile map memory with per-entry valid bits; an unwritten tile is blocked and free.
    logic [TILE_W-1:0] tile_mem [CELLS];
    logic [CELLS-1:0]  tile_v_reg;
    logic [TILE_W-1:0] tile_rd_reg;
    logic              tile_rv_reg;

    // Per-cell record memory: parent direction, path cost, open order.
    logic [REC_W-1:0]     rec_mem [CELLS];
    logic [REC_W-1:0]     rd_reg;
    logic [CELL_BITS-1:0] rd_addr;
    logic                 rec_we;
    logic [CELL_BITS-1:0] rec_waddr;
    logic [REC_W-1:0]     rec_wdata;

    // Open and closed flags of the current search.
    logic [CELLS-1:0] open_reg, closed_reg;

    // Open set scan.
    logic [CELL_BITS-1:0] sc_idx_reg, pend_idx_reg;
    logic [XW-1:0]        sc_x_reg, sc_y_reg, pend_x_reg, pend_y_reg;
    logic                 sc_more_reg, pend_v_reg;

    // Best open cell found by the scan.
    logic                 any_reg;
    logic [CELL_BITS-1:0] best_idx_reg;
    logic [XW-1:0]        best_x_reg, best_y_reg;
    logic [FW-1:0]        best_f_reg;
    logic [CELL_BITS-1:0] best_ord_reg;
    logic [CW-1:0]        best_cost_reg;
    logic [CELL_BITS-1:0] next_ord_reg;

    // Neighbor relaxation.
    logic [1:0]           dir_reg;
    logic                 nb_ok_reg;
    logic [CELL_BITS-1:0] nb_idx_reg;

    // Backtrack walk.
    logic [XW-1:0]    cur_x_reg, cur_y_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Result register.
    gasp_pkg::rsp_t rsp_reg;
    logic           strobe_reg;

    // Fields of the record read back.
    logic [1:0]           p_par;
    logic [CW-1:0]        p_cost;
    logic [CELL_BITS-1:0] p_ord;
    assign p_par  = rd_reg[REC_W-1 -: 2];
    assign p_cost = rd_reg[CW+CELL_BITS-1 : CELL_BITS];
    assign p_ord  = rd_reg[CELL_BITS-1:0];

    // Estimated cost of the pending scan cell and the best-so-far test.
    logic [FW-1:0] pend_f;
    logic          pend_better;
    always_comb
    begin
        pend_f = FW'(p_cost) + FW'(abs_diff(pend_x_reg, tx_reg)) +
                 FW'(abs_diff(pend_y_reg, ty_reg));
        pend_better = pend_v_reg && open_reg[pend_idx_reg] &&
                      (!any_reg || (pend_f < best_f_reg) ||
                       ((pend_f == best_f_reg) && (p_ord < best_ord_reg)));
    end

    // Neighbor coordinates in the current direction.
    logic [XW-1:0]        nb_x, nb_y;
    logic                 nb_ok;
    logic [CELL_BITS-1:0] nb_idx;
    always_comb
    begin
        nb_x  = best_x_reg;
        nb_y  = best_y_reg;
        nb_ok = 1'b0;
        unique case (dir_reg)
            gasp_pkg::DIR_LEFT:
            begin
                nb_ok = (best_x_reg != '0);
                if (nb_ok)
                begin
                    nb_x = best_x_reg - XW'(1);
                end
            end
            gasp_pkg::DIR_RIGHT:
            begin
                nb_ok = ({1'b0, best_x_reg} + SW'(1)) < w_reg;
                if (nb_ok)
                begin
                    nb_x = best_x_reg + XW'(1);
                end
            end
            gasp_pkg::DIR_UP:
            begin
                nb_ok = (best_y_reg != '0);
                if (nb_ok)
                begin
                    nb_y = best_y_reg - XW'(1);
                end
            end
            gasp_pkg::DIR_DOWN:
            begin
                nb_ok = ({1'b0, best_y_reg} + SW'(1)) < h_reg;
                if (nb_ok)
                begin
                    nb_y = best_y_reg + XW'(1);
                end
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
        nb_idx = idx_of(nb_x, nb_y);
    end

    // Relaxation of the neighbor whose tile and record were read.
    logic                walk;
    logic [COST_BITS-1:0] tcost;
    logic [CW:0]         ng_sum;
    logic [CW-1:0]       ng;
    logic                nb_upd_ok, nb_new, nb_cheaper;
    always_comb
    begin
        walk       = tile_rv_reg && tile_rd_reg[COST_BITS];
        tcost      = tile_rv_reg ? tile_rd_reg[COST_BITS-1:0] : '0;
        ng_sum     = (CW+1)'(best_cost_reg) + (CW+1)'(tcost);
        ng         = (ng_sum > (CW+1)'(gasp_pkg::COST_SAT)) ? gasp_pkg::COST_SAT
                                                            : ng_sum[CW-1:0];
        nb_upd_ok  = nb_ok_reg && walk && !closed_reg[nb_idx_reg];
        nb_new     = nb_upd_ok && !open_reg[nb_idx_reg];
        nb_cheaper = nb_upd_ok && open_reg[nb_idx_reg] && (ng < p_cost);
    end

    // Backtrack: end test and step toward the parent.
    logic          bt_last;
    logic [XW-1:0] par_x, par_y;
    always_comb
    begin
        bt_last = ((cur_x_reg == sx_reg) && (cur_y_reg == sy_reg)) || (cnt_reg == LAST_CNT);
        par_x   = cur_x_reg;
        par_y   = cur_y_reg;
        unique case (p_par)
            gasp_pkg::DIR_LEFT:
            begin
                if (cur_x_reg != '0)
                begin
                    par_x = cur_x_reg - XW'(1);
                end
            end
            gasp_pkg::DIR_RIGHT:
            begin
                if (({1'b0, cur_x_reg} + SW'(1)) < GW_S)
                begin
                    par_x = cur_x_reg + XW'(1);
                end
            end
            gasp_pkg::DIR_UP:
            begin
                if (cur_y_reg != '0)
                begin
                    par_y = cur_y_reg - XW'(1);
                end
            end
            gasp_pkg::DIR_DOWN:
            begin
                if (({1'b0, cur_y_reg} + SW'(1)) < GH_S)
                begin
                    par_y = cur_y_reg + XW'(1);
                end
            end
            default:
            begin
                par_x = cur_x_reg;
            end
        endcase
    end

    // Record memory read address and write port selection.
    always_comb
    begin
        priority if (cmd.scan_step)
        begin
            rd_addr = sc_idx_reg;
        end
        else if (cmd.nb_rd)
        begin
            rd_addr = nb_idx;
        end
        else
        begin
            rd_addr = idx_of(cur_x_reg, cur_y_reg);
        end
        rec_we    = 1'b0;
        rec_waddr = nb_idx_reg;
        rec_wdata = {dir_reg ^ 2'd1, ng, p_ord};
        priority if (cmd.start_open)
        begin
            rec_we    = 1'b1;
            rec_waddr = idx_of(sx_reg, sy_reg);
            rec_wdata = {gasp_pkg::DIR_LEFT, CW'(0), CELL_BITS'(0)};
        end
        else if (cmd.nb_upd && nb_new)
        begin
            rec_we    = 1'b1;
            rec_wdata = {dir_reg ^ 2'd1, ng, next_ord_reg};
        end
        else if (cmd.nb_upd && nb_cheaper)
        begin
            rec_we = 1'b1;
        end
        else
        begin
            rec_we = 1'b0;
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rd_reg <= rec_mem[rd_addr];
        if (cmd.tile_wr && (int'(req.cell_x) < GRID_WIDTH) && (int'(req.cell_y) < GRID_HEIGHT))
        begin
            tile_mem[idx_of(req.cell_x, req.cell_y)] <=
                {req.tile_walkable, COST_BITS'(req.tile_cost)};
        end
        tile_rd_reg <= tile_mem[nb_idx];
    end

    // Payload registers of the search.
    always_ff @(posedge clk)
    begin
        if (cmd.srch_load)
        begin
            sx_reg <= req.cell_x;
            sy_reg <= req.cell_y;
            tx_reg <= dx_reg;
            ty_reg <= dy_reg;
            w_reg  <= clamp_size(wu_reg, GW_S);
            h_reg  <= clamp_size(hu_reg, GH_S);
        end
        if (cmd.scan_step && sc_more_reg)
        begin
            pend_idx_reg <= sc_idx_reg;
            pend_x_reg   <= sc_x_reg;
            pend_y_reg   <= sc_y_reg;
        end
        if (pend_better)
        begin
            best_idx_reg  <= pend_idx_reg;
            best_x_reg    <= pend_x_reg;
            best_y_reg    <= pend_y_reg;
            best_f_reg    <= pend_f;
            best_ord_reg  <= p_ord;
            best_cost_reg <= p_cost;
        end
        if (cmd.nb_rd)
        begin
            nb_idx_reg  <= nb_idx;
            nb_ok_reg   <= nb_ok;
            tile_rv_reg <= tile_v_reg[nb_idx];
        end
        if (cmd.bt_init)
        begin
            cur_x_reg <= tx_reg;
            cur_y_reg <= ty_reg;
        end
        else if (cmd.bt_emit)
        begin
            cur_x_reg <= par_x;
            cur_y_reg <= par_y;
        end
        if (cmd.bt_emit)
        begin
            rsp_reg <= '{step_x: cur_x_reg, step_y: cur_y_reg,
                         path_found: 1'b1, last_step: bt_last};
        end
        else if (cmd.emit_none)
        begin
            rsp_reg <= '{step_x: '0, step_y: '0, path_found: 1'b0, last_step: 1'b1};
        end
    end

    // Control registers: configuration, flags, scan and walk counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg       <= '0;
            dy_reg       <= '0;
            wu_reg       <= GW_S;
            hu_reg       <= GH_S;
            tile_v_reg   <= '0;
            open_reg     <= '0;
            closed_reg   <= '0;
            sc_idx_reg   <= '0;
            sc_x_reg     <= '0;
            sc_y_reg     <= '0;
            sc_more_reg  <= 1'b0;
            pend_v_reg   <= 1'b0;
            any_reg      <= 1'b0;
            next_ord_reg <= '0;
            dir_reg      <= '0;
            cnt_reg      <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gasp_pkg::CFG_DEST_X:   dx_reg <= cfg_data[XW-1:0];
                    gasp_pkg::CFG_DEST_Y:   dy_reg <= cfg_data[XW-1:0];
                    gasp_pkg::CFG_WIDTH_U:  wu_reg <= cfg_data;
                    gasp_pkg::CFG_HEIGHT_U: hu_reg <= cfg_data;
                    default:                dx_reg <= dx_reg;
                endcase
            end
            if (cmd.tile_wr && (int'(req.cell_x) < GRID_WIDTH) &&
                (int'(req.cell_y) < GRID_HEIGHT))
            begin
                tile_v_reg[idx_of(req.cell_x, req.cell_y)] <= 1'b1;
            end
            // Search flags.
            if (cmd.srch_load)
            begin
                open_reg   <= '0;
                closed_reg <= '0;
            end
            if (cmd.start_open)
            begin
                open_reg[idx_of(sx_reg, sy_reg)] <= 1'b1;
                next_ord_reg <= CELL_BITS'(1);
            end
            if (cmd.expand)
            begin
                open_reg[best_idx_reg]   <= 1'b0;
                closed_reg[best_idx_reg] <= 1'b1;
                dir_reg                  <= gasp_pkg::DIR_LEFT;
            end
            if (cmd.nb_upd)
            begin
                if (nb_new)
                begin
                    open_reg[nb_idx_reg] <= 1'b1;
                    next_ord_reg         <= next_ord_reg + CELL_BITS'(1);
                end
                dir_reg <= dir_reg + 2'd1;
            end
            // Scan address walk and the registered read behind it.
            if (cmd.scan_clr)
            begin
                sc_idx_reg  <= '0;
                sc_x_reg    <= '0;
                sc_y_reg    <= '0;
                sc_more_reg <= 1'b1;
                pend_v_reg  <= 1'b0;
                any_reg     <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_v_reg <= sc_more_reg;
                if (sc_more_reg)
                begin
                    if (sc_idx_reg == LAST_CELL)
                    begin
                        sc_more_reg <= 1'b0;
                    end
                    else
                    begin
                        sc_idx_reg <= sc_idx_reg + CELL_BITS'(1);
                        if (int'(sc_x_reg) == GRID_WIDTH - 1)
                        begin
                            sc_x_reg <= '0;
                            sc_y_reg <= sc_y_reg + XW'(1);
                        end
                        else
                        begin
                            sc_x_reg <= sc_x_reg + XW'(1);
                        end
                    end
                end
                if (pend_better)
                begin
                    any_reg <= 1'b1;
                end
            end
            // Backtrack counter and result strobe.
            if (cmd.bt_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.bt_emit)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            strobe_reg <= cmd.bt_emit || cmd.emit_none;
        end
    end

    // Status back to the controller.
    always_comb
    begin
        sts.bad_bounds = ({1'b0, sx_reg} >= w_reg) || ({1'b0, sy_reg} >= h_reg) ||
                         ({1'b0, tx_reg} >= w_reg) || ({1'b0, ty_reg} >= h_reg);
        sts.scan_done  = pend_v_reg && (pend_idx_reg == LAST_CELL);
        sts.any_open   = any_reg;
        sts.best_goal  = (best_x_reg == tx_reg) && (best_y_reg == ty_reg);
        sts.dir_last   = (dir_reg == gasp_pkg::DIR_DOWN);
        sts.bt_last    = bt_last;
    end

    assign result        = rsp_reg;
    assign result_strobe = strobe_reg;

endmodule
`default_nettype wire

// ----- rtl/grid_astar_path_search_top.sv -----
// Top level of the grid A* path search block.
//
// A tile item (req_type 0) is written to the map at the edge that accepts it.
// A search item runs A* from the given start to the configured destination.
// Each expansion scans every cell of the grid through the single read port of
// the cell record memory and then relaxes four neighbors; a search whose start
// or destination lies outside the used area ends without a scan. Results
// appear with a one-cycle result_strobe and cannot be held off; busy stays
// high until the last result of a search has been shown, and start is taken
// only while busy is low. Path cells come from destination back to start, the
// final transfer marked by last_step; a search without a path gives one
// transfer with path_found low. There is no clearing pass after reset.
`default_nettype none
module grid_astar_path_search_top #(
    parameter int GRID_WIDTH  = gasp_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gasp_pkg::GRID_HEIGHT_DEF,
    parameter int COST_BITS   = gasp_pkg::COST_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire gasp_pkg::req_t                  req,
    output gasp_pkg::rsp_t                       result,
    output logic                                 result_strobe,
    input  wire logic                            cfg_we,
    input  wire logic [gasp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gasp_pkg::CFG_DATA_W-1:0] cfg_data
);

    gasp_pkg::cmd_t cmd;
    gasp_pkg::sts_t sts;

    // Controller.
    gasp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Datapath.
    gasp_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .COST_BITS   (COST_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule
`default_nettype wire

// ----- rtl/gasp_checker.sv -----
// Port-level checker of the grid path search block and its bind.
`default_nettype none
module gasp_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire gasp_pkg::req_t req,
    input wire gasp_pkg::rsp_t result,
    input wire logic           result_strobe
);

    // A result transfer only happens while a search is in progress.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result transfer while not busy");

    // A not-found result is always the final one and carries zero coordinates.
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.path_found) |->
            (result.last_step && (result.step_x == '0) && (result.step_y == '0)))
        else $error("malformed not-found result");

    // Nothing follows the final result of a search.
    a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last_step) |=> !result_strobe)
        else $error("transfer after final result");

    // An accepted search makes the block busy.
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == gasp_pkg::REQ_SEARCH)) |=> busy)
        else $error("search accepted without busy");

    // A tile write never produces a result.
    a_tile_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == gasp_pkg::REQ_TILE)) |=> !result_strobe)
        else $error("result after tile write");

endmodule

bind grid_astar_path_search_top gasp_checker u_gasp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .result        (result),
    .result_strobe (result_strobe)
);
`default_nettype wire

// ----- sim/grid_astar_path_search_top_test.sv -----
// Testbench for the grid A* path search block: random maps and searches against a predictor.
`timescale 1ns / 1ps

// Tracks the tile map and settings and holds the path cells still to arrive.
class route_tracker;
    logic [3:0] cost_map [64];
    logic       walk_map [64];
    bit         is_open [64];
    bit         is_closed [64];
    logic [1:0] back_dir [64];
    int         g_cost [64];
    logic [5:0] open_rank [64];
    logic [2:0] goal_x, goal_y;
    logic [3:0] cols_used, rows_used;
    gasp_pkg::rsp_t expected_steps [$];
    int         errors;

    function new();
        for (int i = 0; i < 64; i++)
        begin
            cost_map[i] = '0;
            walk_map[i] = 1'b0;
        end
        goal_x = 0;
        goal_y = 0;
        cols_used = 8;
        rows_used = 8;
        errors = 0;
    endfunction

    function void set_reg(logic [gasp_pkg::CFG_IDX_W-1:0] idx,
                          logic [gasp_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            gasp_pkg::CFG_DEST_X:  goal_x = val[2:0];
            gasp_pkg::CFG_DEST_Y:  goal_y = val[2:0];
            gasp_pkg::CFG_WIDTH_U: cols_used = val;
            default:               rows_used = val;
        endcase
    endfunction

    function void add_step(int x, int y, bit found, bit fin);
        gasp_pkg::rsp_t r;
        r.step_x = x[2:0];
        r.step_y = y[2:0];
        r.path_found = found;
        r.last_step = fin;
        expected_steps = {expected_steps, r};
    endfunction

    // A* with Manhattan estimate; ties in estimate go to the earliest opened cell.
    function void plan_route(int sx, int sy);
        int w, h, src, dst, next_rank, best, best_f, f, cx, cy, nx, ny, n, ng, cur, count;
        bit any_open, fin;
        w = (cols_used < 1) ? 1 : (cols_used > 8 ? 8 : cols_used);
        h = (rows_used < 1) ? 1 : (rows_used > 8 ? 8 : rows_used);
        for (int i = 0; i < 64; i++)
        begin
            is_open[i] = 0;
            is_closed[i] = 0;
        end
        if (sx >= w || sy >= h || goal_x >= w || goal_y >= h)
        begin
            add_step(0, 0, 0, 1);
            return;
        end
        src = sy * 8 + sx;
        dst = goal_y * 8 + goal_x;
        is_open[src] = 1;
        g_cost[src] = 0;
        open_rank[src] = 0;
        back_dir[src] = gasp_pkg::DIR_LEFT;
        next_rank = 1;
        forever
        begin
            any_open = 0;
            best = 0;
            best_f = 0;
            for (int i = 0; i < 64; i++)
            begin
                if (!is_open[i]) continue;
                f = g_cost[i] + ((i % 8 > goal_x) ? i % 8 - goal_x : goal_x - i % 8)
                    + ((i / 8 > goal_y) ? i / 8 - goal_y : goal_y - i / 8);
                if (!any_open || f < best_f
                    || (f == best_f && open_rank[i] < open_rank[best]))
                begin
                    any_open = 1;
                    best = i;
                    best_f = f;
                end
            end
            if (!any_open)
            begin
                add_step(0, 0, 0, 1);
                return;
            end
            if (best == dst) break;
            is_open[best] = 0;
            is_closed[best] = 1;
            cx = best % 8;
            cy = best / 8;
            // Neighbors in the order left, right, up, down.
            for (int d = 0; d < 4; d++)
            begin
                nx = cx;
                ny = cy;
                if (d == gasp_pkg::DIR_LEFT)
                begin
                    if (cx == 0) continue;
                    nx = cx - 1;
                end
                else if (d == gasp_pkg::DIR_RIGHT)
                begin
                    if (cx + 1 >= w) continue;
                    nx = cx + 1;
                end
                else if (d == gasp_pkg::DIR_UP)
                begin
                    if (cy == 0) continue;
                    ny = cy - 1;
                end
                else
                begin
                    if (cy + 1 >= h) continue;
                    ny = cy + 1;
                end
                n = ny * 8 + nx;
                if (!walk_map[n] || is_closed[n]) continue;
                ng = g_cost[best] + cost_map[n];
                if (ng > 1023) ng = 1023;
                if (!is_open[n])
                begin
                    is_open[n] = 1;
                    open_rank[n] = next_rank[5:0];
                    next_rank++;
                    g_cost[n] = ng;
                    back_dir[n] = d[1:0] ^ 2'd1;
                end
                else if (ng < g_cost[n])
                begin
                    g_cost[n] = ng;
                    back_dir[n] = d[1:0] ^ 2'd1;
                end
            end
        end
        // Walk back from the destination to the start.
        cur = dst;
        count = 0;
        while (count < 64)
        begin
            cx = cur % 8;
            cy = cur / 8;
            fin = (cur == src) || (count == 63);
            add_step(cx, cy, 1, fin);
            count++;
            if (fin) break;
            case (back_dir[cur])
                gasp_pkg::DIR_LEFT:  cx = (cx > 0) ? cx - 1 : cx;
                gasp_pkg::DIR_RIGHT: cx = (cx < 7) ? cx + 1 : cx;
                gasp_pkg::DIR_UP:    cy = (cy > 0) ? cy - 1 : cy;
                default:             cy = (cy < 7) ? cy + 1 : cy;
            endcase
            cur = cy * 8 + cx;
        end
    endfunction

    function void note_request(gasp_pkg::req_t r);
        if (r.req_type == gasp_pkg::REQ_TILE)
        begin
            cost_map[r.cell_y * 8 + r.cell_x] = r.tile_cost;
            walk_map[r.cell_y * 8 + r.cell_x] = r.tile_walkable;
        end
        else
        begin
            plan_route(r.cell_x, r.cell_y);
        end
    endfunction

    task report(string what);
        $display("%0t: %s", $time, what);
        errors++;
    endtask

    task check_step(gasp_pkg::rsp_t got);
        gasp_pkg::rsp_t want;
        if (expected_steps.size() == 0)
        begin
            report($sformatf("unexpected path result %p", got));
            return;
        end
        want = expected_steps.pop_front();
        if (got.step_x !== want.step_x)
            report($sformatf("step_x %0d, expected %0d", got.step_x, want.step_x));
        if (got.step_y !== want.step_y)
            report($sformatf("step_y %0d, expected %0d", got.step_y, want.step_y));
        if (got.path_found !== want.path_found)
            report($sformatf("path_found %0b, expected %0b", got.path_found, want.path_found));
        if (got.last_step !== want.last_step)
            report($sformatf("last_step %0b, expected %0b", got.last_step, want.last_step));
    endtask
endclass

module grid_astar_path_search_top_test;
    localparam int CYCLE_LIMIT = 8_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    gasp_pkg::req_t req = '0;
    gasp_pkg::rsp_t result;
    logic result_strobe;
    logic cfg_we = 1'b0;
    logic [gasp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gasp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int cycles = 0;
    route_tracker tracker = new();

    grid_astar_path_search_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .result(result), .result_strobe(result_strobe), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Watch accepted requests and result transfers.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy) tracker.note_request(req);
        if (rst_n && result_strobe) tracker.check_step(result);
    end

    // Cycle limit against a hung block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("grid_astar_path_search_top: mismatch");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it.
    task send(logic kind, int x, int y, int cost, logic walk);
        start <= 1'b1;
        req <= '{req_type: kind, cell_x: x[2:0], cell_y: y[2:0],
                 tile_cost: cost[3:0], tile_walkable: walk};
        do @(posedge clk); while (busy);
    endtask

    task pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task settle();
        pause(1);
        while (tracker.expected_steps.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers while the block is idle.
    task set_regs(int dx, int dy, int w, int h);
        int vals [4];
        vals = '{dx, dy, w, h};
        settle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[gasp_pkg::CFG_IDX_W-1:0];
            cfg_data <= vals[i][gasp_pkg::CFG_DATA_W-1:0];
            tracker.set_reg(i[gasp_pkg::CFG_IDX_W-1:0], vals[i][gasp_pkg::CFG_DATA_W-1:0]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    int sizes [5] = '{0, 1, 8, 15, 4};
    int burst, gap, w_sel, h_sel, sx, sy;
    bit gaps_on;

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: start on destination, blocked destination, tile extremes.
        send(gasp_pkg::REQ_SEARCH, 0, 0, 0, 0);
        send(gasp_pkg::REQ_SEARCH, 3, 3, 0, 0);
        send(gasp_pkg::REQ_TILE, 0, 0, 0, 1);
        send(gasp_pkg::REQ_TILE, 1, 0, 15, 1);
        send(gasp_pkg::REQ_TILE, 2, 0, 15, 1);
        send(gasp_pkg::REQ_TILE, 7, 7, 15, 0);
        send(gasp_pkg::REQ_SEARCH, 2, 0, 0, 0);
        send(gasp_pkg::REQ_SEARCH, 3, 3, 0, 0);
        set_regs(7, 7, 15, 0);
        send(gasp_pkg::REQ_SEARCH, 0, 0, 0, 0);
        set_regs(2, 0, 8, 8);
        send(gasp_pkg::REQ_SEARCH, 0, 0, 0, 0);
        send(gasp_pkg::REQ_SEARCH, 7, 7, 0, 0);
        // Open most of the map with random costs.
        for (int i = 0; i < 64; i++)
            send(gasp_pkg::REQ_TILE, i % 8, i / 8, $urandom_range(0, 15),
                 $urandom_range(0, 5) != 0);

        for (int phase = 0; phase < 8; phase++)
        begin
            w_sel = (phase < 5) ? sizes[phase] : $urandom_range(0, 15);
            h_sel = (phase < 5) ? sizes[4 - phase] : $urandom_range(0, 15);
            if (phase > 5)
            begin
                w_sel = 8;
                h_sel = 8;
            end
            set_regs($urandom_range(0, 7), $urandom_range(0, 7), w_sel, h_sel);
            gaps_on = (phase % 3 != 1);
            burst = $urandom_range(1, 8);
            for (int k = 0; k < 52; k++)
            begin
                if (phase == 2 && k == 26) settle();
                if ($urandom_range(0, 2) == 0)
                begin
                    send(gasp_pkg::REQ_TILE, $urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 15), $urandom_range(0, 3) != 0);
                end
                else
                begin
                    sx = $urandom_range(0, 7);
                    sy = $urandom_range(0, 7);
                    if ($urandom_range(0, 4) != 0)
                    begin
                        sx = sx % ((w_sel < 1) ? 1 : (w_sel > 8 ? 8 : w_sel));
                        sy = sy % ((h_sel < 1) ? 1 : (h_sel > 8 ? 8 : h_sel));
                    end
                    send(gasp_pkg::REQ_SEARCH, sx, sy, $urandom_range(0, 15),
                         $urandom_range(0, 1));
                end
                burst--;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 8);
                    gap = $urandom_range(0, 6);
                    if (gaps_on && gap != 0) pause(gap);
                end
            end
        end

        settle();
        repeat (200) @(posedge clk);
        if (tracker.errors == 0 && tracker.expected_steps.size() == 0)
            $display("grid_astar_path_search_top: match");
        else
            $display("grid_astar_path_search_top: mismatch");
        $finish;
    end
endmodule

// ----- grid_astar_path_search_top.f -----
rtl/gasp_pkg.sv
rtl/gasp_ctrl.sv
rtl/gasp_dp.sv
rtl/grid_astar_path_search_top.sv
rtl/gasp_checker.sv
sim/grid_astar_path_search_top_test.sv
